>>> src/separable_gaussian_blur_rgb_core_assert.svh
// Assertion macros for the separable blur core checker.
// Needs nothing else; included by the checker file.
`ifndef SEPARABLE_GAUSSIAN_BLUR_RGB_CORE_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_RGB_CORE_ASSERT_SVH

// check a consequence in the next cycle, ignored while in reset
`define SGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgb check failed");

// check a consequence in the next cycle, also evaluated during reset
`define SGB_ASSERT_RESET(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sgb reset check failed");

`endif

>>> src/sgb_pkg.sv
// Shared constants, types and helper functions of the separable blur core.
// No dependencies.
package sgb_pkg;

  localparam int MAX_RADIUS = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int WIN_LEN    = 2 * MAX_RADIUS + 1;
  localparam int LINE_COUNT = 2 * MAX_RADIUS;

  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);
  localparam int ROWS_W  = ROW_W + 1;
  localparam int COLX_W  = DIM_W + 1;
  localparam int SLOT_W  = $clog2(LINE_COUNT);
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int TAP_W   = $clog2(WIN_LEN);
  localparam int ACC_W   = 24 + TAP_W;
  localparam int NORM_W  = 17;
  localparam int PROD_W  = ACC_W + NORM_W;
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH * MAX_RADIUS
                                  + MAX_RADIUS + 2);
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_DATA_W = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    REG_BLUR_ENABLE  = 3'd0,
    REG_RADIUS       = 3'd1,
    REG_COEF_LOW     = 3'd2,
    REG_COEF_HIGH    = 3'd3,
    REG_NORM_RECIP   = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } reg_idx_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  typedef struct packed {
    logic              blur;
    logic [RAD_W-1:0]  radius;
    logic [63:0]       coef_lo;
    logic [63:0]       coef_hi;
    logic [NORM_W-1:0] norm;
    logic [DIM_W-1:0]  width;
    logic [HGT_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic              blur;
    logic [23:0]       pix;
    logic [ROW_W-1:0]  y;
    logic [SLOT_W-1:0] ymod;
    logic [COL_W-1:0]  c;
    logic              wr;
    logic              emit;
    logic              last;
    logic [COL_W-1:0]  ox;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE, B_COL_RD, B_COL_ACC, B_COL_MUL, B_COL_CLP,
    B_ROW_ACC, B_ROW_MUL, B_ROW_CLP, B_OUT
  } back_state_t;

  function automatic logic [15:0] tap_coef(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [RAD_W-1:0] k);
    logic [63:0] sh;
    sh = '0;
    if (int'(k) < 4) begin
      sh = lo >> (16 * int'(k));
    end else if (int'(k) < 8) begin
      sh = hi >> (16 * (int'(k) - 4));
    end
    return sh[15:0];
  endfunction

  function automatic logic [7:0] scale_clamp(input logic [PROD_W-1:0] p);
    logic [PROD_W-32:0] v;
    v = p[PROD_W-1:31];
    return (v > (PROD_W-31)'(255)) ? 8'hFF : v[7:0];
  endfunction

endpackage

>>> src/separable_gaussian_blur_rgb_core.sv
// Top level of the separable RGB blur core: configuration registers, front end,
// command queue and filter engine. Depends on sgb_pkg, sgb_front, sgb_cmd_queue, sgb_back.
//
//   channel  handshake         payload
//   input    in_push / in_full in_op, in_red_in, in_green_in, in_blue_in
//   result   out_pop/out_empty out_red_out, out_green_out, out_blue_out, out_frame_last
//   config   cfg_we            cfg_index, cfg_data
//
// The line store is read once per column tap, and the column and row passes share the
// multiply-accumulate lanes. Up to four items queue ahead of the engine; a waiting result
// stalls only the engine. Synchronous reset, no clearing pass.
module separable_gaussian_blur_rgb_core import sgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_op,
  input  logic [7:0]            in_red_in,
  input  logic [7:0]            in_green_in,
  input  logic [7:0]            in_blue_in,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_red_out,
  output logic [7:0]            out_green_out,
  output logic [7:0]            out_blue_out,
  output logic                  out_frame_last,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 blur_r;
  logic [2:0]           radius_r;
  logic [63:0]          coef_lo_r, coef_hi_r;
  logic [NORM_W-1:0]    norm_r;
  logic [CFG_DIM_W-1:0] width_r, height_r;
  cfg_t                 cfg;
  cmd_t                 cmd, q_head;
  logic                 cmd_push, q_full, q_empty, q_pop;
  logic [23:0]          out_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_r    <= 1'b0;
      radius_r  <= 3'd3;
      coef_lo_r <= '0;
      coef_hi_r <= '0;
      norm_r    <= NORM_W'(65536);
      width_r   <= CFG_DIM_W'(1024);
      height_r  <= CFG_DIM_W'(1024);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BLUR_ENABLE:  blur_r    <= cfg_data[0];
        REG_RADIUS:       radius_r  <= cfg_data[2:0];
        REG_COEF_LOW:     coef_lo_r <= cfg_data[63:0];
        REG_COEF_HIGH:    coef_hi_r <= cfg_data[63:0];
        REG_NORM_RECIP:   norm_r    <= cfg_data[NORM_W-1:0];
        REG_IMAGE_WIDTH:  width_r   <= cfg_data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r  <= cfg_data[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.blur    = blur_r;
    cfg.radius  = (int'(radius_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);
    cfg.coef_lo = coef_lo_r;
    cfg.coef_hi = coef_hi_r;
    cfg.norm    = norm_r;
    if (width_r == '0) begin
      cfg.width = DIM_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      cfg.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg.width = DIM_W'(width_r);
    end
    if (height_r == '0) begin
      cfg.height = HGT_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      cfg.height = HGT_W'(MAX_HEIGHT);
    end else begin
      cfg.height = HGT_W'(height_r);
    end
  end

  sgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_push  (in_push),
    .in_op    (in_op),
    .in_pix   ({in_red_in, in_green_in, in_blue_in}),
    .q_full   (q_full),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  sgb_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  sgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_pix   (out_pix),
    .out_last  (out_frame_last)
  );

  assign out_red_out   = out_pix[23:16];
  assign out_green_out = out_pix[15:8];
  assign out_blue_out  = out_pix[7:0];

endmodule

>>> src/sgb_front.sv
// Front end: raster counters, classification of incoming items, command issue.
// Depends on sgb_pkg.
module sgb_front import sgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_push,
  input  logic        in_op,
  input  logic [23:0] in_pix,
  input  logic        q_full,
  output logic        in_full,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [COL_W-1:0]  col_r, col_nxt, ox_r, ox_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] ymod_r, ymod_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt, n_r, n_nxt;

  logic [CNT_W-1:0]  total, thresh;
  logic [ROW_W-1:0]  h_row;
  logic              accept, base_clr, end_row, emit, is_pad;
  logic [COL_W-1:0]  c0;
  logic [ROW_W-1:0]  y0;
  logic [SLOT_W-1:0] ym0;
  logic [CNT_W-1:0]  p0;
  logic [DIM_W-1:0]  c_inc, ox_inc;
  logic [ROW_W:0]    y_inc;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign is_pad  = (in_op == OP_PAD);
  assign total   = CNT_W'(cfg.width) * CNT_W'(cfg.height);
  assign thresh  = CNT_W'(cfg.radius) * CNT_W'(cfg.width) + CNT_W'(cfg.radius);
  assign h_row   = ROW_W'(cfg.height);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ymod_nxt = ymod_r;
    pos_nxt  = pos_r;
    n_nxt    = n_r;
    ox_nxt   = ox_r;
    cmd_push = 1'b0;
    cmd      = '0;
    base_clr = !cfg.blur && (row_r >= h_row);
    c0       = base_clr ? '0 : col_r;
    y0       = base_clr ? '0 : row_r;
    ym0      = base_clr ? '0 : ymod_r;
    p0       = base_clr ? '0 : pos_r;
    c_inc    = DIM_W'(c0) + DIM_W'(1);
    y_inc    = {1'b0, y0} + (ROW_W+1)'(1);
    end_row  = (c_inc >= cfg.width);
    emit     = (pos_r >= thresh);
    ox_inc   = DIM_W'(ox_r) + DIM_W'(1);
    cmd.pix  = in_pix;
    cmd.y    = y0;
    cmd.ymod = ym0;
    cmd.c    = c0;
    cmd.ox   = ox_r;
    if (accept) begin
      if (!cfg.blur) begin
        col_nxt  = c0;
        row_nxt  = y0;
        ymod_nxt = ym0;
        pos_nxt  = p0;
        if (base_clr) begin
          n_nxt  = '0;
          ox_nxt = '0;
        end
        if (!is_pad) begin
          cmd_push = 1'b1;
          cmd.blur = 1'b0;
          cmd.wr   = 1'b1;
          cmd.emit = 1'b1;
          cmd.last = (y_inc >= (ROW_W+1)'(cfg.height)) && end_row;
          if (end_row) begin
            col_nxt  = '0;
            row_nxt  = y_inc[ROW_W-1:0];
            ymod_nxt = (int'(ym0) == LINE_COUNT - 1) ? '0 : ym0 + SLOT_W'(1);
          end else begin
            col_nxt  = c_inc[COL_W-1:0];
          end
          pos_nxt = p0 + CNT_W'(1);
          n_nxt   = p0 + CNT_W'(1);
          ox_nxt  = end_row ? '0 : c_inc[COL_W-1:0];
          if (cmd.last) begin
            col_nxt  = '0;
            row_nxt  = '0;
            ymod_nxt = '0;
            pos_nxt  = '0;
            n_nxt    = '0;
            ox_nxt   = '0;
          end
        end
      end else if (!((row_r < h_row) && is_pad)) begin
        cmd_push = 1'b1;
        cmd.blur = 1'b1;
        cmd.wr   = (row_r < h_row);
        cmd.emit = emit;
        cmd.last = emit && ((n_r + CNT_W'(1)) == total);
        if (end_row) begin
          col_nxt  = '0;
          row_nxt  = y_inc[ROW_W-1:0];
          ymod_nxt = (int'(ym0) == LINE_COUNT - 1) ? '0 : ym0 + SLOT_W'(1);
        end else begin
          col_nxt  = c_inc[COL_W-1:0];
        end
        pos_nxt = pos_r + CNT_W'(1);
        if (emit) begin
          n_nxt  = n_r + CNT_W'(1);
          ox_nxt = (ox_inc >= cfg.width) ? '0 : ox_inc[COL_W-1:0];
        end
        if (n_nxt >= total) begin
          col_nxt  = '0;
          row_nxt  = '0;
          ymod_nxt = '0;
          pos_nxt  = '0;
          n_nxt    = '0;
          ox_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ymod_r <= '0;
      pos_r  <= '0;
      n_r    <= '0;
      ox_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ymod_r <= ymod_nxt;
      pos_r  <= pos_nxt;
      n_r    <= n_nxt;
      ox_r   <= ox_nxt;
    end
  end

endmodule

>>> src/sgb_cmd_queue.sv
// Short command queue between the front end and the filter engine.
// Depends on sgb_pkg.
module sgb_cmd_queue import sgb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

>>> src/sgb_back.sv
// Filter engine: line store, column pass, row window, row pass, result register.
// Depends on sgb_pkg.
module sgb_back import sgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [23:0] out_pix,
  output logic        out_last
);

  logic [23:0] line_mem [LINE_COUNT * MAX_WIDTH];

  back_state_t               state_r, state_nxt;
  cmd_t                      cmd_r;
  logic [TAP_W-1:0]          j_r;
  logic signed [ROWS_W-1:0]  row_r;
  logic signed [COLX_W-1:0]  colx_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [ACC_W-1:0]          acc_r  [3];
  logic [PROD_W-1:0]         prod_r [3];
  logic [23:0]               rdata_r;
  logic [23:0]               win_r  [WIN_LEN];
  logic [23:0]               res_r;
  logic                      res_last_r;
  logic                      out_valid_r;
  logic [23:0]               out_pix_r;
  logic                      out_last_r;

  logic [TAP_W-1:0]  two_r, r_t, tap_dist;
  logic [15:0]       coef;
  logic [23:0]       tap_pix;
  logic              tap_ok, out_free, mem_we, out_load, tap_last;
  logic [ADDR_W-1:0] mem_waddr;
  logic [23:0]       mem_wdata, clamped;
  logic [TAP_W:0]    slot_sum;
  logic [SLOT_W-1:0] slot_init;

  assign two_r     = TAP_W'({cfg.radius, 1'b0});
  assign r_t       = TAP_W'(cfg.radius);
  assign out_free  = !out_valid_r || out_pop;
  assign tap_last  = (j_r == two_r);
  assign out_empty = !out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:    if (!q_empty) state_nxt = q_head.blur ? B_COL_RD : B_OUT;
      B_COL_RD:  state_nxt = B_COL_ACC;
      B_COL_ACC: state_nxt = tap_last ? B_COL_MUL : B_COL_RD;
      B_COL_MUL: state_nxt = B_COL_CLP;
      B_COL_CLP: state_nxt = cmd_r.emit ? B_ROW_ACC : B_IDLE;
      B_ROW_ACC: state_nxt = tap_last ? B_ROW_MUL : B_ROW_ACC;
      B_ROW_MUL: state_nxt = B_ROW_CLP;
      B_ROW_CLP: state_nxt = B_OUT;
      B_OUT:     if (out_free) state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    out_load  = (state_r == B_OUT) && out_free;
    mem_we    = 1'b0;
    mem_waddr = {cmd_r.ymod, cmd_r.c};
    mem_wdata = cmd_r.pix;
    if (q_pop && !q_head.blur) begin
      mem_we    = 1'b1;
      mem_waddr = {q_head.ymod, q_head.c};
      mem_wdata = q_head.pix;
    end else if ((state_r == B_COL_CLP) && cmd_r.wr) begin
      mem_we = 1'b1;
    end
    tap_dist = (j_r >= r_t) ? (j_r - r_t) : (r_t - j_r);
    coef = tap_coef(cfg.coef_lo, cfg.coef_hi, tap_dist[RAD_W-1:0]);
    if (state_r == B_ROW_ACC) begin
      tap_ok  = (colx_r >= 0) && (colx_r < $signed(COLX_W'(cfg.width)));
      tap_pix = win_r[two_r - j_r];
    end else begin
      tap_ok  = (row_r >= 0) && (row_r < $signed(ROWS_W'(cfg.height)));
      tap_pix = tap_last ? cmd_r.pix : rdata_r;
    end
    if (!tap_ok) begin
      tap_pix = '0;
    end
    clamped  = {scale_clamp(prod_r[0]), scale_clamp(prod_r[1]), scale_clamp(prod_r[2])};
    slot_sum = (TAP_W+1)'(q_head.ymod) + (TAP_W+1)'(LINE_COUNT) - (TAP_W+1)'(two_r);
    slot_init = (slot_sum >= (TAP_W+1)'(LINE_COUNT)) ?
                SLOT_W'(slot_sum - (TAP_W+1)'(LINE_COUNT)) : SLOT_W'(slot_sum);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == B_COL_RD) begin
      rdata_r <= line_mem[{slot_r, cmd_r.c}];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= q_head;
      j_r        <= '0;
      row_r      <= $signed(ROWS_W'(q_head.y)) - $signed(ROWS_W'(two_r));
      slot_r     <= slot_init;
      res_r      <= q_head.pix;
      res_last_r <= q_head.last;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end
    if ((state_r == B_COL_ACC) || (state_r == B_ROW_ACC)) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_r[i] + ACC_W'(tap_pix[8*(2-i) +: 8]) * ACC_W'(coef);
      end
      j_r    <= j_r + TAP_W'(1);
      row_r  <= row_r + ROWS_W'(1);
      colx_r <= colx_r + COLX_W'(1);
      slot_r <= (int'(slot_r) == LINE_COUNT - 1) ? '0 : slot_r + SLOT_W'(1);
    end
    if ((state_r == B_COL_MUL) || (state_r == B_ROW_MUL)) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PROD_W'(acc_r[i]) * PROD_W'(cfg.norm);
      end
    end
    if (state_r == B_COL_CLP) begin
      j_r    <= '0;
      colx_r <= $signed(COLX_W'(cmd_r.ox)) - $signed(COLX_W'(cfg.radius));
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end
    if (state_r == B_ROW_CLP) begin
      res_r      <= clamped;
      res_last_r <= cmd_r.last;
    end
    if (out_load) begin
      out_pix_r  <= res_r;
      out_last_r <= res_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= '0;
    end else if (state_r == B_COL_CLP) begin
      for (int i = WIN_LEN - 1; i > 0; i--) win_r[i] <= win_r[i-1];
      win_r[0] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> src/sgb_checker.sv
// Port-level checker for the separable blur core, bound to the top level.
// Depends on separable_gaussian_blur_rgb_core_assert.svh.
`include "separable_gaussian_blur_rgb_core_assert.svh"

module sgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic       out_frame_last
);

  logic [24:0] out_data;

  assign out_data = {out_red_out, out_green_out, out_blue_out, out_frame_last};

  `SGB_ASSERT_RESET(a_reset_empty, clk, !rst_n, out_empty)
  `SGB_ASSERT_RESET(a_reset_not_full, clk, !rst_n, !in_full)
  `SGB_ASSERT_NEXT(a_result_held, clk, rst_n, !out_empty && !out_pop, !out_empty)
  `SGB_ASSERT_NEXT(a_payload_held, clk, rst_n, !out_empty && !out_pop, $stable(out_data))

endmodule

bind separable_gaussian_blur_rgb_core sgb_checker u_sgb_checker (.*);

>>> sim/separable_gaussian_blur_rgb_core_test.sv
// Self-checking testbench for separable_gaussian_blur_rgb_core: directed table, then random
// frames with drain pads under several idle/stall mixes, checked against an in-bench predictor.
// Depends on sgb_pkg and the core RTL only.
`timescale 1ns / 100ps

module separable_gaussian_blur_rgb_core_test;
  import sgb_pkg::*;

  localparam int SETTLE_CYCLES = 320;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blurred_px_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [63:0] data;
    logic        op;
    logic [23:0] pix;
    bit          typed;
    bit          typed_res;
    blurred_px_t typed_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_op = OP_PIXEL;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_red_out, out_green_out, out_blue_out;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  separable_gaussian_blur_rgb_core dut (.*);

  // predictor state and register mirror
  logic [23:0] line_mem [LINE_COUNT*MAX_WIDTH];
  logic [23:0] win [WIN_LEN];
  int unsigned pos_col, pos_row, emitted;
  bit          blur_on;
  bit [2:0]    rad;
  bit [63:0]   coef_lo, coef_hi;
  bit [16:0]   norm;
  bit [10:0]   width_reg, height_reg;

  blurred_px_t expected_px [$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int phases = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(bit [10:0] v, int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic bit [15:0] coef_at(int k);
    if (k < 4) return 16'(coef_lo >> (16 * k));
    if (k < 8) return 16'(coef_hi >> (16 * (k - 4)));
    return '0;
  endfunction

  function automatic logic [7:0] norm_clip(longint unsigned acc);
    longint unsigned v;
    v = (acc * longint'(norm)) >> 31;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [23:0] col_pass_px(int y, int c, logic [23:0] cur, int r, int h);
    longint unsigned sr, sg, sb;
    int rr;
    logic [23:0] px;
    bit [15:0] cf;
    sr = 0; sg = 0; sb = 0;
    for (int k = -r; k <= r; k++) begin
      rr = y - r + k;
      if (rr < 0 || rr >= h) continue;
      px = (rr == y) ? cur : line_mem[(rr % LINE_COUNT) * MAX_WIDTH + c];
      cf = coef_at(k < 0 ? -k : k);
      sr += longint'(px[23:16]) * cf;
      sg += longint'(px[15:8]) * cf;
      sb += longint'(px[7:0]) * cf;
    end
    return {norm_clip(sr), norm_clip(sg), norm_clip(sb)};
  endfunction

  function automatic logic [23:0] row_pass_px(int ox, int r, int w);
    longint unsigned sr, sg, sb;
    int col;
    logic [23:0] px;
    bit [15:0] cf;
    sr = 0; sg = 0; sb = 0;
    for (int k = -r; k <= r; k++) begin
      col = ox + k;
      if (col < 0 || col >= w) continue;
      px = win[r - k];
      cf = coef_at(k < 0 ? -k : k);
      sr += longint'(px[23:16]) * cf;
      sg += longint'(px[15:8]) * cf;
      sb += longint'(px[7:0]) * cf;
    end
    return {norm_clip(sr), norm_clip(sg), norm_clip(sb)};
  endfunction

  task automatic blur_step(input logic op, input logic [23:0] cur, output bit got,
                           output blurred_px_t res);
    int unsigned w, h, r, y, c, n;
    longint unsigned total;
    bit last;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = rad;
    total = longint'(w) * h;
    got = 0;
    res = '0;
    if (!blur_on) begin
      if (pos_row >= h) begin pos_row = 0; pos_col = 0; emitted = 0; end
      if (op == OP_PAD) return;
      y = pos_row;
      c = pos_col;
      line_mem[(y % LINE_COUNT) * MAX_WIDTH + c] = cur;
      last = (y + 1 >= h) && (c + 1 >= w);
      res = {cur, last};
      got = 1;
      emitted = y * w + c + 1;
      if (c + 1 >= w) begin pos_col = 0; pos_row = y + 1; end
      else pos_col = c + 1;
      if (last) begin pos_row = 0; pos_col = 0; emitted = 0; end
      return;
    end
    y = pos_row;
    c = pos_col;
    if (y < h && op == OP_PAD) return;
    for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = col_pass_px(y, c, cur, r, h);
    if (y < h) line_mem[(y % LINE_COUNT) * MAX_WIDTH + c] = cur;
    if (longint'(y) * w + c >= longint'(r) * w + r) begin
      n = emitted;
      res = {row_pass_px(n % w, r, w), (longint'(n) + 1 == total)};
      emitted = n + 1;
      got = 1;
    end
    if (c + 1 >= w) begin pos_col = 0; pos_row = y + 1; end
    else pos_col = c + 1;
    if (emitted >= total) begin pos_row = 0; pos_col = 0; emitted = 0; end
  endtask

  task automatic push_item(input logic op, input logic [23:0] pix, input bit typed = 0,
                           input bit typed_res = 0, input blurred_px_t typed_val = '0);
    bit got;
    blurred_px_t res;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    {in_red_in, in_green_in, in_blue_in} <= pix;
    do @(posedge clk); while (in_full);
    blur_step(op, pix, got, res);
    if (typed) begin
      got = typed_res;
      res = typed_val;
    end
    if (got) expected_px = {expected_px, res};
    items_sent++;
  endtask

  // drain outstanding transactions, then give the engine time to finish result-less items
  task automatic settle();
    in_push <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BLUR_ENABLE:  blur_on = v[0];
      REG_RADIUS:       rad = v[2:0];
      REG_COEF_LOW:     coef_lo = v;
      REG_COEF_HIGH:    coef_hi = v;
      REG_NORM_RECIP:   norm = v[16:0];
      REG_IMAGE_WIDTH:  width_reg = v[10:0];
      REG_IMAGE_HEIGHT: height_reg = v[10:0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t cfg_row(reg_idx_t idx, logic [63:0] data);
    stim_row_t s;
    s.is_cfg = 1;
    s.idx = idx;
    s.data = data;
    s.op = OP_PIXEL;
    s.pix = '0;
    s.typed = 0;
    s.typed_res = 0;
    s.typed_val = '0;
    return s;
  endfunction

  function automatic stim_row_t item_row(logic op, logic [23:0] pix, bit typed = 0,
                                         bit typed_res = 0, bit last = 0);
    stim_row_t s;
    s.is_cfg = 0;
    s.idx = REG_BLUR_ENABLE;
    s.data = '0;
    s.op = op;
    s.pix = pix;
    s.typed = typed;
    s.typed_res = typed_res;
    s.typed_val = {pix, last};
    return s;
  endfunction

  task automatic random_config(input int p);
    int unsigned r, sum;
    logic [63:0] lo, hi;
    bit [15:0] c0;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    r = $urandom_range(0, 7);
    write_reg(REG_BLUR_ENABLE, (p == 2) ? 0 : ($urandom_range(99) < 85));
    case (p)
      1: begin
        r = 7;
        write_reg(REG_BLUR_ENABLE, 1);
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd2047);
      end
      2: begin
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd5);
      end
      default: begin
        write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 12));
        write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 8));
      end
    endcase
    write_reg(REG_RADIUS, r);
    write_reg(REG_COEF_LOW, lo);
    write_reg(REG_COEF_HIGH, hi);
    sum = 0;
    for (int k = 0; k <= int'(r); k++) begin
      c0 = (k < 4) ? 16'(lo >> (16 * k)) : 16'(hi >> (16 * (k - 4)));
      sum += (k == 0) ? c0 : 2 * c0;
    end
    case ($urandom_range(0, 7))
      0: write_reg(REG_NORM_RECIP, 0);
      1: write_reg(REG_NORM_RECIP, 17'h1FFFF);
      2: write_reg(REG_NORM_RECIP, $urandom_range(0, 17'h1FFFF));
      default: write_reg(REG_NORM_RECIP, (sum == 0) ? 65536 :
                                         ((64'd1 << 31) / sum > 17'h1FFFF) ? 17'h1FFFF :
                                         (64'd1 << 31) / sum);
    endcase
  endtask

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // results: check each popped transaction against the oldest expectation
  always @(posedge clk) begin
    blurred_px_t exp_px;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h %h last %b", $time, out_red_out,
                 out_green_out, out_blue_out, out_frame_last);
      end else begin
        exp_px = expected_px.pop_front();
        if (out_red_out !== exp_px.red) begin
          errors++;
          $display("%0t: red expected %h actual %h", $time, exp_px.red, out_red_out);
        end
        if (out_green_out !== exp_px.green) begin
          errors++;
          $display("%0t: green expected %h actual %h", $time, exp_px.green, out_green_out);
        end
        if (out_blue_out !== exp_px.blue) begin
          errors++;
          $display("%0t: blue expected %h actual %h", $time, exp_px.blue, out_blue_out);
        end
        if (out_frame_last !== exp_px.last) begin
          errors++;
          $display("%0t: frame_last expected %b actual %b", $time, exp_px.last,
                   out_frame_last);
        end
      end
    end
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
    $display("separable_gaussian_blur_rgb_core: mismatch");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    int random_items;
    int unsigned w, h, frames;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    pos_col = 0; pos_row = 0; emitted = 0;
    blur_on = 0; rad = 3; coef_lo = '0; coef_hi = '0; norm = 17'd65536;
    width_reg = 11'd1024; height_reg = 11'd1024;

    // pass-through frame, 4x2
    rows = {rows, cfg_row(REG_IMAGE_WIDTH, 4)};
    rows = {rows, cfg_row(REG_IMAGE_HEIGHT, 2)};
    rows = {rows, item_row(OP_PIXEL, 24'h000000, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'hFFFFFF, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'hFF0000, 1, 1, 0)};
    rows = {rows, item_row(OP_PAD,   24'hFFFFFF, 1, 0, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'h00FF00, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'h0000FF, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'h55AA55, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'hAA55AA, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'h123456, 1, 1, 1)};
    // unit kernel, zero radius, width written as zero: identity, one column of three
    rows = {rows, cfg_row(REG_BLUR_ENABLE, 1)};
    rows = {rows, cfg_row(REG_RADIUS, 0)};
    rows = {rows, cfg_row(REG_COEF_LOW, 64'h0000_0000_0000_8000)};
    rows = {rows, cfg_row(REG_NORM_RECIP, 65536)};
    rows = {rows, cfg_row(REG_IMAGE_WIDTH, 0)};
    rows = {rows, cfg_row(REG_IMAGE_HEIGHT, 3)};
    rows = {rows, item_row(OP_PIXEL, 24'hFFFFFF, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'h000000, 1, 1, 0)};
    rows = {rows, item_row(OP_PIXEL, 24'hA5C3F0, 1, 1, 1)};
    rows = {rows, item_row(OP_PAD,   24'h000000, 1, 0, 0)};
    // radius one, largest norm: edge darkening, saturation, pixel during drain
    rows = {rows, cfg_row(REG_RADIUS, 1)};
    rows = {rows, cfg_row(REG_COEF_LOW, 64'h0000_0000_4000_8000)};
    rows = {rows, cfg_row(REG_COEF_HIGH, 64'hFFFF_8000_0001_7FFF)};
    rows = {rows, cfg_row(REG_NORM_RECIP, 17'h1FFFF)};
    rows = {rows, cfg_row(REG_IMAGE_WIDTH, 2)};
    rows = {rows, cfg_row(REG_IMAGE_HEIGHT, 2)};
    rows = {rows, item_row(OP_PIXEL, 24'hFFFFFF)};
    rows = {rows, item_row(OP_PAD,   24'h123456)};
    rows = {rows, item_row(OP_PIXEL, 24'h808080)};
    rows = {rows, item_row(OP_PIXEL, 24'h000000)};
    rows = {rows, item_row(OP_PIXEL, 24'h7F7F7F)};
    rows = {rows, item_row(OP_PIXEL, 24'hFFFFFF)};
    rows = {rows, item_row(OP_PAD,   24'h000000)};
    rows = {rows, item_row(OP_PAD,   24'hFFFFFF)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (i > 0 && !rows[i-1].is_cfg) settle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        push_item(rows[i].op, rows[i].pix, rows[i].typed, rows[i].typed_res,
                  rows[i].typed_val);
      end
    end
    phases = 3;

    random_items = 0;
    for (int p = 0; random_items < RANDOM_ITEMS || p < 4; p++) begin
      settle();
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 56; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 56; end
        default: begin sender_idle_pct = 35; stall_pct = 35; end
      endcase
      random_config(p);
      phases++;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      frames = (p == 1 || p == 2) ? 1 : $urandom_range(1, 3);
      repeat (frames) begin
        for (int unsigned i = 0; i < w * h; i++) begin
          if ($urandom_range(99) < 4) push_item(OP_PAD, 24'($urandom));
          push_item(OP_PIXEL, random_pixel());
          random_items++;
        end
        while (pos_row != 0 || pos_col != 0) begin
          push_item(($urandom_range(99) < 80) ? OP_PAD : OP_PIXEL, random_pixel());
          random_items++;
        end
      end
    end

    settle();
    $display("%0d transactions in, %0d results checked, %0d register settings",
             items_sent, results_seen, phases);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("separable_gaussian_blur_rgb_core: match");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_px.size());
      $display("separable_gaussian_blur_rgb_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sgb_pkg.sv
src/sgb_front.sv
src/sgb_cmd_queue.sv
src/sgb_back.sv
src/separable_gaussian_blur_rgb_core.sv
src/sgb_checker.sv
sim/separable_gaussian_blur_rgb_core_test.sv
